>>> src/xwc_pkg.sv
// Package for the XML well-formedness checker.
// Holds the item types, event and status codes, character constants and sizes.
// No dependencies.
`timescale 1ns / 1ps
package xwc_pkg;

	localparam int DEF_MAX_DEPTH = 16;
	localparam int DEF_MAX_NAME  = 32;
	localparam int CNT_W         = 24;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;

	localparam logic [1:0] EV_OPEN    = 2'd0;
	localparam logic [1:0] EV_CLOSE   = 2'd1;
	localparam logic [1:0] EV_CONTENT = 2'd2;
	localparam logic [1:0] EV_FINAL   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_NAME = 3'd1;
	localparam logic [2:0] ST_ATTR     = 3'd2;
	localparam logic [2:0] ST_MISMATCH = 3'd3;
	localparam logic [2:0] ST_UNCLOSED = 3'd4;
	localparam logic [2:0] ST_NOT_XML  = 3'd5;

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_end;
	} in_t;

	typedef struct packed {
		logic [1:0]       event_res;
		logic [4:0]       depth;
		logic [7:0]       content_byte;
		logic [2:0]       status;
		logic [CNT_W-1:0] line;
		logic [CNT_W-1:0] column;
	} out_t;

	// Classified item passed from the front to the back.
	typedef struct packed {
		logic [7:0] symbol;
		logic       is_end;
		logic       is_lt;
		logic       is_gt;
		logic       is_slash;
		logic       is_ws;
		logic       is_quote;
		logic       is_nl;
	} cls_t;

	typedef struct packed {
		logic init;
		logic space;
		logic content;
		logic closing;
		logic single;
		logic attr;
	} mode_t;

endpackage

>>> src/xwc_front.sv
// Front of the XML checker: classifies each input byte and queues it.
// Uses xwc_pkg. Two-entry queue toward the back.
`timescale 1ns / 1ps
module xwc_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  xwc_pkg::in_t in_data,
	output logic         q_valid,
	input  logic         q_pop,
	output xwc_pkg::cls_t q_item
);
	import xwc_pkg::*;

	cls_t       cls;
	cls_t       buf_q [2];
	logic       head_q;
	logic       tail_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	always_comb begin
		cls.symbol   = in_data.symbol;
		cls.is_end   = in_data.is_end;
		cls.is_lt    = in_data.symbol == CH_LT;
		cls.is_gt    = in_data.symbol == CH_GT;
		cls.is_slash = in_data.symbol == CH_SLASH;
		cls.is_ws    = in_data.symbol inside {[CH_TAB:CH_CR], CH_SP};
		cls.is_quote = in_data.symbol inside {CH_DQ, CH_SQ};
		cls.is_nl    = in_data.symbol == CH_NL;
	end

	assign in_ready = count_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign q_valid  = count_q != 2'd0;
	assign pop      = q_pop && q_valid;
	assign q_item   = buf_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[tail_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			tail_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				tail_q <= ~tail_q;
			end
			if (pop) begin
				head_q <= ~head_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> src/xwc_back.sv
// Back of the XML checker: tag modes, name stack, error latch and result register.
// Uses xwc_pkg. Holds the name memory and the name-length memory.
`timescale 1ns / 1ps
module xwc_back #(
	parameter int MAX_DEPTH = xwc_pkg::DEF_MAX_DEPTH,
	parameter int MAX_NAME  = xwc_pkg::DEF_MAX_NAME
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  xwc_pkg::cls_t q_item,
	output logic          out_valid,
	input  logic          out_ready,
	output xwc_pkg::out_t out_data
);
	import xwc_pkg::*;

	localparam int DW  = $clog2(MAX_DEPTH + 1);
	localparam int NW  = $clog2(MAX_NAME + 1);
	localparam int LIW = $clog2(MAX_DEPTH);
	localparam int AW  = $clog2(MAX_DEPTH * MAX_NAME);
	localparam int NS  = MAX_DEPTH * MAX_NAME;

	logic [7:0]    name_mem [NS];
	logic [NW-1:0] len_mem [MAX_DEPTH];

	mode_t            mode_q, n_mode;
	logic             found_q, n_found;
	logic [2:0]       err_q, n_err;
	logic [NW-1:0]    nl_q, n_nl;
	logic             mism_q, n_mism;
	logic [DW-1:0]    depth_q, n_depth;
	logic [CNT_W-1:0] line_q, n_line, col_q, n_col;
	logic [CNT_W-1:0] eline_q, n_eline, ecol_q, n_ecol;
	logic [7:0]       first_q, n_first;
	logic [7:0]       rd_name_q;
	logic [NW-1:0]    rd_len_q;

	logic             out_valid_q;
	out_t             out_q;
	logic             emit;
	out_t             res;
	logic             fail;
	logic [2:0]       fail_code;
	logic             name_we, len_we;
	logic [AW-1:0]    name_wa, name_ra;
	logic [LIW-1:0]   len_wa, len_ra;
	logic [DW-1:0]    n_top;
	logic             init, closing;
	cls_t             c;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign c         = q_item;
	assign init      = mode_q.init;
	assign closing   = mode_q.closing;

	always_comb begin
		n_mode    = mode_q;
		n_found   = found_q;
		n_err     = err_q;
		n_nl      = nl_q;
		n_mism    = mism_q;
		n_depth   = depth_q;
		n_line    = line_q;
		n_col     = col_q;
		n_eline   = eline_q;
		n_ecol    = ecol_q;
		n_first   = first_q;
		emit      = 1'b0;
		fail      = 1'b0;
		fail_code = ST_OK;
		name_we   = 1'b0;
		len_we    = 1'b0;
		res       = '0;
		if (c.is_end) begin
			emit          = 1'b1;
			res.event_res = EV_FINAL;
			res.status    = err_q;
			res.line      = eline_q;
			res.column    = ecol_q;
			if (err_q == ST_OK) begin
				if (depth_q != '0) begin
					res.status = ST_UNCLOSED;
				end else if (!found_q) begin
					res.status = ST_NOT_XML;
				end
				if (res.status != ST_OK) begin
					res.line   = line_q;
					res.column = col_q;
				end else begin
					res.line   = '0;
					res.column = '0;
				end
			end
			n_mode  = '0;
			n_found = 1'b0;
			n_err   = ST_OK;
			n_nl    = '0;
			n_mism  = 1'b0;
			n_depth = '0;
			n_line  = CNT_W'(1);
			n_col   = CNT_W'(1);
			n_eline = '0;
			n_ecol  = '0;
			n_first = '0;
		end else if (err_q == ST_OK) begin
			if (c.is_lt && (init || closing) && !mode_q.attr) begin
				fail = 1'b1; fail_code = ST_BAD_NAME;
			end else if (c.is_ws && (init || closing)) begin
				n_mode.space = 1'b1;
				if (nl_q == '0) begin
					fail = 1'b1; fail_code = ST_BAD_NAME;
				end
			end else if (c.is_lt) begin
				n_mode.init = 1'b1;
			end else if (c.is_slash) begin
				if (init && nl_q == '0) begin
					n_mode.init    = 1'b0;
					n_mode.closing = 1'b1;
					n_mism         = 1'b0;
				end else if (init) begin
					if (!mode_q.attr) begin
						n_mode.single = 1'b1;
					end
				end else if (closing) begin
					fail = 1'b1; fail_code = ST_BAD_NAME;
				end else if (depth_q == '0) begin
					fail = 1'b1; fail_code = ST_NOT_XML;
				end else begin
					emit             = 1'b1;
					res.event_res    = EV_CONTENT;
					res.content_byte = c.symbol;
				end
			end else if (c.is_gt && init) begin
				n_mode.init    = 1'b0;
				n_mode.space   = 1'b0;
				n_mode.single  = 1'b0;
				n_mode.content = !mode_q.single;
				if (nl_q == '0) begin
					fail = 1'b1; fail_code = ST_BAD_NAME;
				end else if ((first_q == CH_QUEST || first_q == CH_BANG) && !mode_q.attr) begin
					n_found        = 1'b1;
					n_mode.content = 1'b0;
				end else if (mode_q.attr) begin
					fail = 1'b1; fail_code = ST_ATTR;
				end else if (mode_q.single) begin
					n_found = 1'b1;
					if (depth_q != '0) begin
						n_mode.content = 1'b1;
					end
				end else if (depth_q >= DW'(MAX_DEPTH)) begin
					fail = 1'b1; fail_code = ST_BAD_NAME;
				end else begin
					n_found       = 1'b1;
					len_we        = 1'b1;
					n_depth       = depth_q + DW'(1);
					emit          = 1'b1;
					res.event_res = EV_OPEN;
				end
				n_nl = '0;
			end else if (c.is_gt && closing) begin
				n_mode.space   = 1'b0;
				n_mode.content = 1'b0;
				n_mode.closing = 1'b0;
				if (depth_q == '0 || mism_q || nl_q != rd_len_q) begin
					fail = 1'b1; fail_code = ST_MISMATCH;
				end else begin
					n_depth        = depth_q - DW'(1);
					n_nl           = '0;
					n_mism         = 1'b0;
					n_mode.content = depth_q != DW'(1);
					emit           = 1'b1;
					res.event_res  = EV_CLOSE;
				end
			end else if ((init || closing) && !mode_q.space) begin
				if (nl_q >= NW'(MAX_NAME)) begin
					fail = 1'b1; fail_code = ST_BAD_NAME;
				end else begin
					if (init) begin
						if (nl_q == '0) begin
							n_first = c.symbol;
						end
						name_we = depth_q < DW'(MAX_DEPTH);
					end else if (depth_q != '0) begin
						if (nl_q >= rd_len_q || rd_name_q != c.symbol) begin
							n_mism = 1'b1;
						end
					end
					n_nl = nl_q + NW'(1);
				end
			end else if (init && c.is_quote) begin
				n_mode.attr = ~mode_q.attr;
			end else if (init || closing) begin
				// Attribute text inside a tag is skipped.
			end else if (mode_q.content) begin
				if (depth_q == '0) begin
					fail = 1'b1; fail_code = ST_NOT_XML;
				end else begin
					emit             = 1'b1;
					res.event_res    = EV_CONTENT;
					res.content_byte = c.symbol;
				end
			end else if (c.is_ws) begin
				// Whitespace between tags is allowed.
			end else begin
				fail = 1'b1; fail_code = ST_NOT_XML;
			end

			if (fail) begin
				emit    = 1'b0;
				n_err   = fail_code;
				n_eline = line_q;
				n_ecol  = col_q;
			end else if (c.is_nl) begin
				if (line_q != CNT_MAX) begin
					n_line = line_q + CNT_W'(1);
				end
				n_col = CNT_W'(1);
			end else if (col_q != CNT_MAX) begin
				n_col = col_q + CNT_W'(1);
			end
		end
		// The final status reports the depth reached before the document is cleared.
		res.depth = c.is_end ? 5'(depth_q) : 5'(n_depth);
	end

	// Memory addresses: writes go to the row at the current depth, reads are
	// addressed from the next state for the top row and registered.
	always_comb begin
		n_top   = (q_pop ? n_depth : depth_q) - DW'(1);
		name_wa = AW'(AW'(depth_q[LIW-1:0]) * AW'(MAX_NAME) + AW'(nl_q));
		name_ra = AW'(AW'(n_top[LIW-1:0]) * AW'(MAX_NAME) + AW'(q_pop ? n_nl : nl_q));
		len_wa  = depth_q[LIW-1:0];
		len_ra  = n_top[LIW-1:0];
	end

	always_ff @(posedge clk) begin
		if (q_pop && name_we) begin
			name_mem[name_wa] <= c.symbol;
		end
		if (q_pop && len_we) begin
			len_mem[len_wa] <= nl_q;
		end
		rd_name_q <= name_mem[name_ra];
		if (q_pop && len_we && len_wa == len_ra) begin
			rd_len_q <= nl_q;
		end else begin
			rd_len_q <= len_mem[len_ra];
		end
		if (q_pop && emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			found_q     <= 1'b0;
			err_q       <= ST_OK;
			nl_q        <= '0;
			mism_q      <= 1'b0;
			depth_q     <= '0;
			line_q      <= CNT_W'(1);
			col_q       <= CNT_W'(1);
			eline_q     <= '0;
			ecol_q      <= '0;
			first_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mode_q  <= n_mode;
				found_q <= n_found;
				err_q   <= n_err;
				nl_q    <= n_nl;
				mism_q  <= n_mism;
				depth_q <= n_depth;
				line_q  <= n_line;
				col_q   <= n_col;
				eline_q <= n_eline;
				ecol_q  <= n_ecol;
				first_q <= n_first;
			end
			if (q_pop) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/xml_wellformedness_checker.sv
// Top level of the XML well-formedness checker.
// Depends on xwc_pkg, xwc_front and xwc_back.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | in_data  (symbol, is_end)
//   out     | output    | out_valid/out_ready | out_data (event, depth, byte, status, line, column)
//
// One item per cycle sustained while the output does not stall; an accepted item
// is written into the front queue, and when the back pops it the back updates
// its state and the result register together.
// Name bytes are compared against a registered read of the name memory whose
// address is set from the next state.
// Reset clears all control state; the name memories need no clearing.
// The two-entry queue lets the front keep taking items while the output stalls, until it is full.
`timescale 1ns / 1ps
module xml_wellformedness_checker #(
	parameter int MAX_DEPTH = xwc_pkg::DEF_MAX_DEPTH,
	parameter int MAX_NAME  = xwc_pkg::DEF_MAX_NAME
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  xwc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output xwc_pkg::out_t out_data
);
	import xwc_pkg::*;

	logic q_valid;
	logic q_pop;
	cls_t q_item;

	xwc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	xwc_back #(
		.MAX_DEPTH(MAX_DEPTH),
		.MAX_NAME (MAX_NAME)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

>>> tb/sv/xwc_checker.sv
// Result checker for the XML well-formedness checker testbench.
// Watches the input and output channels, predicts each result and compares it.
// Depends on xwc_pkg.
`timescale 1ns / 1ps
module xwc_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  xwc_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  xwc_pkg::out_t out_data,
	output int            fail_count,
	output int            pending
);
	import xwc_pkg::*;

	localparam int DEPTH_LIM = DEF_MAX_DEPTH;
	localparam int NAME_LIM  = DEF_MAX_NAME;

	mode_t            mode;
	logic             seen_tag;
	logic [2:0]       err_code;
	int               name_len;
	logic             close_bad;
	int               level;
	logic [7:0]       names [DEPTH_LIM][NAME_LIM];
	int               name_lens [DEPTH_LIM];
	logic [CNT_W-1:0] cur_line, cur_col, err_line, err_col;
	logic [7:0]       lead_byte;
	out_t             expected_q [$];

	function automatic bit blank(logic [7:0] s);
		return s == CH_SP || (s >= CH_TAB && s <= CH_CR);
	endfunction

	task automatic clear_doc();
		mode = '0;
		seen_tag = 0;
		err_code = ST_OK;
		name_len = 0;
		close_bad = 0;
		level = 0;
		cur_line = 1;
		cur_col = 1;
		lead_byte = 0;
		err_line = 0;
		err_col = 0;
	endtask

	task automatic flag_error(logic [2:0] code);
		err_code = code;
		err_line = cur_line;
		err_col = cur_col;
	endtask

	task automatic push_event(logic [1:0] ev, logic [7:0] b, logic [2:0] st,
			logic [CNT_W-1:0] ln, logic [CNT_W-1:0] col);
		out_t r;
		r.event_res = ev;
		r.depth = level[4:0];
		r.content_byte = b;
		r.status = st;
		r.line = ln;
		r.column = col;
		expected_q.insert(expected_q.size(), r);
	endtask

	task automatic parse_byte(logic [7:0] s);
		bit single;
		if (s == CH_LT && (mode.init || mode.closing) && !mode.attr) begin
			flag_error(ST_BAD_NAME);
		end else if (blank(s) && (mode.init || mode.closing)) begin
			mode.space = 1;
			if (name_len == 0) flag_error(ST_BAD_NAME);
		end else if (s == CH_LT) begin
			mode.init = 1;
		end else if (s == CH_SLASH) begin
			if (mode.init && name_len == 0) begin
				mode.init = 0;
				mode.closing = 1;
				close_bad = 0;
			end else if (mode.init) begin
				if (!mode.attr) mode.single = 1;
			end else if (mode.closing) begin
				flag_error(ST_BAD_NAME);
			end else if (level == 0) begin
				flag_error(ST_NOT_XML);
			end else begin
				push_event(EV_CONTENT, s, ST_OK, 0, 0);
			end
		end else if (s == CH_GT && mode.init) begin
			single = mode.single;
			mode.init = 0;
			mode.space = 0;
			mode.single = 0;
			mode.content = !single;
			if (name_len == 0) begin
				flag_error(ST_BAD_NAME);
			end else if ((lead_byte == CH_QUEST || lead_byte == CH_BANG) && !mode.attr) begin
				seen_tag = 1;
				mode.content = 0;
			end else if (mode.attr) begin
				flag_error(ST_ATTR);
			end else if (single) begin
				seen_tag = 1;
				if (level > 0) mode.content = 1;
			end else if (level >= DEPTH_LIM) begin
				flag_error(ST_BAD_NAME);
			end else begin
				seen_tag = 1;
				name_lens[level] = name_len;
				level++;
				push_event(EV_OPEN, 0, ST_OK, 0, 0);
			end
			name_len = 0;
		end else if (s == CH_GT && mode.closing) begin
			mode.space = 0;
			mode.content = 0;
			mode.closing = 0;
			if (level == 0 || close_bad || name_len != name_lens[level-1]) begin
				flag_error(ST_MISMATCH);
			end else begin
				level--;
				name_len = 0;
				close_bad = 0;
				if (level > 0) mode.content = 1;
				push_event(EV_CLOSE, 0, ST_OK, 0, 0);
			end
		end else if ((mode.init || mode.closing) && !mode.space) begin
			if (name_len >= NAME_LIM) begin
				flag_error(ST_BAD_NAME);
			end else begin
				if (mode.init) begin
					if (name_len == 0) lead_byte = s;
					if (level < DEPTH_LIM) names[level][name_len] = s;
				end else if (level > 0) begin
					if (name_len >= name_lens[level-1] || names[level-1][name_len] != s)
						close_bad = 1;
				end
				name_len++;
			end
		end else if (mode.init && (s == CH_DQ || s == CH_SQ)) begin
			mode.attr = !mode.attr;
		end else if (mode.init || mode.closing) begin
			// Attribute text inside a tag is skipped.
		end else if (mode.content) begin
			if (level == 0) flag_error(ST_NOT_XML);
			else push_event(EV_CONTENT, s, ST_OK, 0, 0);
		end else if (!blank(s)) begin
			flag_error(ST_NOT_XML);
		end
		if (err_code == ST_OK) begin
			if (s == CH_NL) begin
				if (cur_line != CNT_MAX) cur_line++;
				cur_col = 1;
			end else if (cur_col != CNT_MAX) begin
				cur_col++;
			end
		end
	endtask

	task automatic accept_item(in_t it);
		logic [2:0]       st;
		logic [CNT_W-1:0] ln, col;
		if (it.is_end) begin
			st = err_code;
			ln = err_line;
			col = err_col;
			if (st == ST_OK) begin
				if (level > 0) st = ST_UNCLOSED;
				else if (!seen_tag) st = ST_NOT_XML;
				if (st != ST_OK) begin
					ln = cur_line;
					col = cur_col;
				end else begin
					ln = 0;
					col = 0;
				end
			end
			push_event(EV_FINAL, 0, st, ln, col);
			clear_doc();
		end else if (err_code == ST_OK) begin
			parse_byte(it.symbol);
		end
	endtask

	task automatic report(string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		clear_doc();
	end

	assign pending = expected_q.size();

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report($sformatf("unexpected result %p", out_data));
				end else begin
					want = expected_q.pop_front();
					if (out_data.event_res != want.event_res)
						report($sformatf("event %0d want %0d", out_data.event_res, want.event_res));
					if (out_data.depth != want.depth)
						report($sformatf("depth %0d want %0d", out_data.depth, want.depth));
					if (out_data.content_byte != want.content_byte)
						report($sformatf("byte %h want %h", out_data.content_byte,
							want.content_byte));
					if (out_data.status != want.status)
						report($sformatf("status %0d want %0d", out_data.status, want.status));
					if (out_data.line != want.line)
						report($sformatf("line %0d want %0d", out_data.line, want.line));
					if (out_data.column != want.column)
						report($sformatf("column %0d want %0d", out_data.column, want.column));
				end
			end
			if (in_valid && in_ready) accept_item(in_data);
		end
	end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the XML well-formedness checker.
// Drives documents byte by byte, stalls the result side and gives the verdict.
// Depends on xwc_pkg, xwc_checker and the block under test.
`timescale 1ns / 1ps
module tb;
	import xwc_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_t  in_data;
	out_t out_data;
	int   fail_count, pending;
	int   cycles;
	int   sent;
	bit   calm;

	xml_wellformedness_checker dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	xwc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The result side stalls in bursts until the calm tail of the run.
	initial begin
		int n;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			n = $urandom_range(1, 12);
			repeat (n) @(negedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 9);
				repeat (n) @(negedge clk);
			end
		end
	end

	// Sends one item and waits at rising edges until it is taken.
	task automatic send(logic [7:0] s, logic e);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.symbol <= s;
		in_data.is_end <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_str(string t);
		for (int i = 0; i < t.len(); i++) send(t[i], 1'b0);
	endtask

	task automatic finish_doc();
		send(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic string rand_name(int len);
		string t;
		t = "";
		for (int i = 0; i < len; i++) t = {t, string'(byte'("a" + $urandom_range(0, 25)))};
		return t;
	endfunction

	// Builds a nested random document, sometimes damaged.
	task automatic random_doc();
		string stk [$];
		string nm;
		int steps;
		send_str("<?xml v='1'?>\n");
		steps = $urandom_range(4, 30);
		for (int i = 0; i < steps; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: if (stk.size() < 17) begin
					nm = rand_name($urandom_range(1, stk.size() == 0 ? 33 : 6));
					stk.insert(stk.size(), nm);
					if ($urandom_range(0, 3) == 0) send_str({"<", nm, " a=\"x>y\">"});
					else send_str({"<", nm, ">"});
				end
				3, 4: if (stk.size() > 0) begin
					nm = stk[stk.size() - 1];
					stk.delete(stk.size() - 1);
					if ($urandom_range(0, 15) == 0) nm = {nm, "q"};
					send_str({"</", nm, ">"});
				end
				5: send_str({"<", rand_name(3), "/>"});
				6: send(8'h0A, 1'b0);
				7: send(8'($urandom_range(0, 255)), 1'b0);
				default: send_str(rand_name($urandom_range(1, 4)));
			endcase
		end
		if ($urandom_range(0, 3) != 0) begin
			while (stk.size() > 0) begin
				nm = stk[stk.size() - 1];
				stk.delete(stk.size() - 1);
				send_str({"</", nm, ">"});
			end
		end
		finish_doc();
	endtask

	initial begin
		cycles = 0;
		sent = 0;
		calm = 0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed documents.
		send_str("<a>x/y</a>");
		finish_doc();
		send_str("<?p?><!d><b/>\n<c k=\"v\" j='w'>\t</c>");
		finish_doc();
		send_str("<a><b></a>");
		finish_doc();
		send_str("/");
		finish_doc();
		send_str("</a>");
		finish_doc();
		send_str("<a b=\"c>");
		finish_doc();
		send_str("<>");
		finish_doc();
		send_str("<a <");
		finish_doc();
		send_str({"<", rand_name(33), ">"});
		finish_doc();
		for (int i = 0; i < 17; i++) send_str("<d>");
		finish_doc();
		send_str("<a>");
		finish_doc();
		finish_doc();
		send_str("zz");
		finish_doc();
		send(8'hFF, 1'b0);
		send(8'h00, 1'b0);
		finish_doc();

		while (sent < 1500) begin
			if (sent > 1200) calm = 1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)), 1'b0);
				finish_doc();
			end else begin
				random_doc();
			end
		end
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/xwc_pkg.sv
src/xwc_front.sv
src/xwc_back.sv
src/xml_wellformedness_checker.sv
tb/sv/xwc_checker.sv
tb/sv/tb.sv
